// ===== hw/rtl/rsd_pkg.sv =====
`timescale 1ns / 1ps
package rsd_pkg;

   localparam int DATA_BYTES   = 223;
   localparam int PARITY_BYTES = 32;
   localparam int BLOCK_LEN    = DATA_BYTES + PARITY_BYTES;
   localparam int HALF         = PARITY_BYTES / 2;
   localparam int POS_W        = $clog2(BLOCK_LEN);
   localparam int ADDR_W       = POS_W + 1;
   localparam int CNT_W        = $clog2(BLOCK_LEN + 1);
   localparam int LW           = $clog2(PARITY_BYTES + 1);
   localparam int SW           = $clog2(PARITY_BYTES);
   localparam int HW           = (HALF > 1) ? $clog2(HALF) : 1;

   typedef logic [7:0] gf_type;
   typedef gf_type [PARITY_BYTES-1:0] syn_set_type;
   typedef gf_type [255:0] gf_table_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_rel_type;

   function automatic gf_type gf_mul(gf_type a, gf_type b);
      gf_type r;
      gf_type x;
      r = '0;
      x = a;
      for (int n = 0; n < 8; n++) begin
         if (b[n]) r = r ^ x;
         x = x[7] ? ((x << 1) ^ 8'h1D) : (x << 1);
      end
      return r;
   endfunction

   function automatic gf_table_type make_exp();
      gf_table_type t;
      gf_type x;
      x = 8'h01;
      for (int e = 0; e < 256; e++) begin
         t[e] = x;
         x = gf_mul(x, 8'h02);
      end
      return t;
   endfunction

   localparam gf_table_type GF_EXP = make_exp();

   function automatic gf_table_type make_inv();
      gf_table_type t;
      t = '0;
      for (int e = 0; e < 255; e++) begin
         t[GF_EXP[e]] = (e == 0) ? GF_EXP[0] : GF_EXP[255 - e];
      end
      return t;
   endfunction

   localparam gf_table_type GF_INV = make_inv();

endpackage

// ===== hw/rtl/rsd_ram.sv =====
`timescale 1ns / 1ps
module rsd_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [rsd_pkg::ADDR_W-1:0] wr_addr,
   input  rsd_pkg::gf_type           wr_data,
   input  logic                      rd_en,
   input  logic [rsd_pkg::ADDR_W-1:0] rd_addr,
   output rsd_pkg::gf_type           rd_data
);

   rsd_pkg::gf_type mem [2**rsd_pkg::ADDR_W];
   rsd_pkg::gf_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rsd_front.sv =====
`timescale 1ns / 1ps
module rsd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   output logic                        ram_wr_en,
   output logic [rsd_pkg::ADDR_W-1:0]  ram_wr_addr,
   output rsd_pkg::gf_type             ram_wr_data,
   output logic                        q_push,
   output rsd_pkg::syn_set_type        q_data,
   input  logic                        q_full,
   input  rsd_pkg::bank_rel_type       rel
);

   logic [rsd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      wbank_ff, wbank_in;
   logic [1:0]                busy_ff, busy_in;
   rsd_pkg::syn_set_type      syn_ff, syn_in, syn_next;
   logic                      accept, block_end;

   assign req_stall = busy_ff[wbank_ff] | q_full;
   assign accept    = req_valid & ~req_stall;
   assign block_end = accept && (pos_ff == rsd_pkg::POS_W'(rsd_pkg::BLOCK_LEN - 1));

   // Horner step per syndrome: S_i = S_i * alpha^i + r
   always_comb begin
      for (int i = 0; i < rsd_pkg::PARITY_BYTES; i++) begin
         syn_next[i] = rsd_pkg::gf_mul(syn_ff[i], rsd_pkg::GF_EXP[i]) ^ req_rx_byte;
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      wbank_in = wbank_ff;
      busy_in  = busy_ff;
      syn_in   = syn_ff;
      if (rel.valid) busy_in[rel.bank] = 1'b0;
      if (accept) begin
         if (block_end) begin
            pos_in            = '0;
            syn_in            = '0;
            wbank_in          = ~wbank_ff;
            busy_in[wbank_ff] = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
            syn_in = syn_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         wbank_ff <= 1'b0;
         busy_ff  <= '0;
         syn_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         wbank_ff <= wbank_in;
         busy_ff  <= busy_in;
         syn_ff   <= syn_in;
      end
   end

   assign ram_wr_en   = accept;
   assign ram_wr_addr = {wbank_ff, pos_ff};
   assign ram_wr_data = req_rx_byte;
   assign q_push      = block_end;
   assign q_data      = syn_next;

endmodule

// ===== hw/rtl/rsd_queue.sv =====
`timescale 1ns / 1ps
module rsd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsd_pkg::syn_set_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 out_valid,
   output rsd_pkg::syn_set_type head_data
);

   rsd_pkg::syn_set_type mem_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/rsd_back.sv =====
`timescale 1ns / 1ps
module rsd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  rsd_pkg::syn_set_type       q_data,
   output logic                       q_pop,
   output logic                       ram_rd_en,
   output logic [rsd_pkg::ADDR_W-1:0] ram_rd_addr,
   input  rsd_pkg::gf_type            ram_rd_data,
   output rsd_pkg::bank_rel_type      rel,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [63:0]                rsp_data_word,
   output logic [3:0]                 rsp_byte_count,
   output logic                       rsp_block_ok,
   output logic [4:0]                 rsp_errors_fixed,
   output logic                       rsp_last
);

   localparam int T  = rsd_pkg::PARITY_BYTES;
   localparam int H  = rsd_pkg::HALF;
   localparam int PW = rsd_pkg::POS_W;
   localparam int LW = rsd_pkg::LW;
   localparam int SW = rsd_pkg::SW;
   localparam int HW = rsd_pkg::HW;
   localparam int CW = rsd_pkg::CNT_W;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_BM_START  = 5'd1;
   localparam logic [4:0] S_BM_DELTA  = 5'd2;
   localparam logic [4:0] S_BM_INV    = 5'd3;
   localparam logic [4:0] S_BM_UPD    = 5'd4;
   localparam logic [4:0] S_BM_END    = 5'd5;
   localparam logic [4:0] S_CHIEN     = 5'd6;
   localparam logic [4:0] S_CHIEN_END = 5'd7;
   localparam logic [4:0] S_OM_START  = 5'd8;
   localparam logic [4:0] S_OM_LOOP   = 5'd9;
   localparam logic [4:0] S_FY_START  = 5'd10;
   localparam logic [4:0] S_FY_NUM    = 5'd11;
   localparam logic [4:0] S_FY_X2     = 5'd12;
   localparam logic [4:0] S_FY_DEN    = 5'd13;
   localparam logic [4:0] S_FY_DIV    = 5'd14;
   localparam logic [4:0] S_FY_MAG    = 5'd15;
   localparam logic [4:0] S_EM_RD     = 5'd16;
   localparam logic [4:0] S_EM_DATA   = 5'd17;
   localparam logic [4:0] S_EM_PUSH   = 5'd18;
   localparam logic [4:0] S_FAIL      = 5'd19;
   localparam logic [4:0] S_DONE      = 5'd20;

   logic [4:0]           state_ff, state_in;
   logic                 bank_ff, bank_in;
   rsd_pkg::syn_set_type syn_ff, syn_in;
   rsd_pkg::gf_type      loc_ff [T];      // coefficient j+1; coefficient 0 is one
   rsd_pkg::gf_type      loc_in [T];
   rsd_pkg::gf_type      prior_ff [T];
   rsd_pkg::gf_type      prior_in [T];
   rsd_pkg::gf_type      sh [T+1];
   rsd_pkg::gf_type      chien_ff [T];
   rsd_pkg::gf_type      chien_in [T];
   logic [LW-1:0]        len_ff, len_in;
   logic [PW-1:0]        i_ff, i_in;
   logic [LW-1:0]        j_ff, j_in;
   rsd_pkg::gf_type      acc_ff, acc_in;
   rsd_pkg::gf_type      dinv_ff, dinv_in;
   rsd_pkg::gf_type      xr_ff, xr_in;
   logic [CW-1:0]        roots_ff, roots_in;
   logic [PW-1:0]        rpos_ff [H];
   logic [PW-1:0]        rpos_in [H];
   rsd_pkg::gf_type      rxinv_ff [H];
   rsd_pkg::gf_type      rxinv_in [H];
   rsd_pkg::gf_type      omega_ff [H];
   rsd_pkg::gf_type      omega_in [H];
   rsd_pkg::gf_type      mag_ff [H];
   rsd_pkg::gf_type      mag_in [H];
   logic [LW-1:0]        k_ff, k_in;
   rsd_pkg::gf_type      xinv_ff, xinv_in;
   rsd_pkg::gf_type      xinv2_ff, xinv2_in;
   rsd_pkg::gf_type      num_ff, num_in;
   logic [LW-1:0]        nerr_ff, nerr_in;
   rsd_pkg::gf_type [7:0] word_ff, word_in;
   logic [3:0]           slot_ff, slot_in;
   logic [PW-1:0]        dpos_ff, dpos_in;
   logic                 ov_ff, ov_in;
   logic [63:0]          oword_ff, oword_in;
   logic [3:0]           ocount_ff, ocount_in;
   logic                 ook_ff, ook_in;
   logic [4:0]           ofixed_ff, ofixed_in;
   logic                 olast_ff, olast_in;

   logic                 out_free;
   logic [PW-1:0]        sidx;
   rsd_pkg::gf_type      chien_sum, corr, fixed_byte;

   assign out_free = ~ov_ff | ~rsp_stall;
   assign sidx     = i_ff - PW'(j_ff);

   always_comb begin
      chien_sum = 8'h01;
      for (int j = 0; j < T; j++) chien_sum = chien_sum ^ chien_ff[j];
   end

   always_comb begin
      corr = '0;
      for (int k = 0; k < H; k++) begin
         if ((nerr_ff > LW'(k)) && (rpos_ff[k] == dpos_ff)) corr = corr ^ mag_ff[k];
      end
      fixed_byte = ram_rd_data ^ corr;
   end

   always_comb begin
      sh[0] = '0;
      for (int j = 1; j <= T; j++) sh[j] = prior_ff[j-1];
   end

   always_comb begin
      state_in  = state_ff;
      bank_in   = bank_ff;
      syn_in    = syn_ff;
      loc_in    = loc_ff;
      prior_in  = prior_ff;
      chien_in  = chien_ff;
      len_in    = len_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      acc_in    = acc_ff;
      dinv_in   = dinv_ff;
      xr_in     = xr_ff;
      roots_in  = roots_ff;
      rpos_in   = rpos_ff;
      rxinv_in  = rxinv_ff;
      omega_in  = omega_ff;
      mag_in    = mag_ff;
      k_in      = k_ff;
      xinv_in   = xinv_ff;
      xinv2_in  = xinv2_ff;
      num_in    = num_ff;
      nerr_in   = nerr_ff;
      word_in   = word_ff;
      slot_in   = slot_ff;
      dpos_in   = dpos_ff;
      ov_in     = ov_ff & rsp_stall;
      oword_in  = oword_ff;
      ocount_in = ocount_ff;
      ook_in    = ook_ff;
      ofixed_in = ofixed_ff;
      olast_in  = olast_ff;
      q_pop     = 1'b0;
      ram_rd_en = 1'b0;
      rel       = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               syn_in = q_data;
               if (q_data == '0) begin
                  nerr_in  = '0;
                  dpos_in  = '0;
                  slot_in  = '0;
                  word_in  = '0;
                  state_in = S_EM_RD;
               end else begin
                  for (int j = 0; j < T; j++) begin
                     loc_in[j]   = '0;
                     prior_in[j] = '0;
                  end
                  prior_in[0] = 8'h01;
                  len_in      = '0;
                  i_in        = '0;
                  state_in    = S_BM_START;
               end
            end
         end
         S_BM_START: begin
            acc_in   = syn_ff[SW'(i_ff)];
            j_in     = LW'(1);
            state_in = S_BM_DELTA;
         end
         S_BM_DELTA: begin
            if ((j_ff <= len_ff) && (PW'(j_ff) <= i_ff)) begin
               acc_in = acc_ff ^ rsd_pkg::gf_mul(loc_ff[SW'(j_ff - LW'(1))],
                                                 syn_ff[sidx[SW-1:0]]);
               j_in   = j_ff + 1'b1;
            end else begin
               state_in = S_BM_INV;
            end
         end
         S_BM_INV: begin
            dinv_in  = rsd_pkg::GF_INV[acc_ff];
            state_in = S_BM_UPD;
         end
         S_BM_UPD: begin
            for (int j = 0; j < T; j++) prior_in[j] = sh[j];
            if (acc_ff != '0) begin
               for (int j = 0; j < T; j++) begin
                  loc_in[j] = loc_ff[j] ^ rsd_pkg::gf_mul(acc_ff, sh[j+1]);
               end
               if ({len_ff, 1'b0} <= (LW+1)'(i_ff)) begin
                  len_in      = LW'(i_ff + PW'(1) - PW'(len_ff));
                  prior_in[0] = dinv_ff;
                  for (int j = 1; j < T; j++) begin
                     prior_in[j] = rsd_pkg::gf_mul(loc_ff[j-1], dinv_ff);
                  end
               end
            end
            i_in     = i_ff + 1'b1;
            state_in = (i_ff == PW'(T - 1)) ? S_BM_END : S_BM_START;
         end
         S_BM_END: begin
            if (len_ff > LW'(H)) begin
               state_in = S_FAIL;
            end else begin
               for (int j = 0; j < T; j++) begin
                  chien_in[j] = (LW'(j) < len_ff) ? loc_ff[j] : 8'h00;
               end
               xr_in    = 8'h01;
               i_in     = '0;
               roots_in = '0;
               state_in = S_CHIEN;
            end
         end
         S_CHIEN: begin
            if (chien_sum == '0) begin
               if (roots_ff < CW'(H)) begin
                  rpos_in[HW'(roots_ff)]  = PW'(rsd_pkg::BLOCK_LEN - 1) - i_ff;
                  rxinv_in[HW'(roots_ff)] = xr_ff;
               end
               roots_in = roots_ff + 1'b1;
            end
            for (int j = 0; j < T; j++) begin
               chien_in[j] = rsd_pkg::gf_mul(chien_ff[j], rsd_pkg::GF_EXP[254 - j]);
            end
            xr_in = rsd_pkg::gf_mul(xr_ff, rsd_pkg::GF_EXP[254]);
            i_in  = i_ff + 1'b1;
            if (i_ff == PW'(rsd_pkg::BLOCK_LEN - 1)) state_in = S_CHIEN_END;
         end
         S_CHIEN_END: begin
            if (roots_ff != CW'(len_ff)) begin
               state_in = S_FAIL;
            end else begin
               i_in     = '0;
               state_in = S_OM_START;
            end
         end
         S_OM_START: begin
            acc_in   = syn_ff[SW'(i_ff)];
            j_in     = LW'(1);
            state_in = S_OM_LOOP;
         end
         S_OM_LOOP: begin
            if (PW'(j_ff) <= i_ff) begin
               acc_in = acc_ff ^ rsd_pkg::gf_mul(loc_ff[SW'(j_ff - LW'(1))],
                                                 syn_ff[sidx[SW-1:0]]);
               j_in   = j_ff + 1'b1;
            end else begin
               omega_in[HW'(i_ff)] = acc_ff;
               i_in                = i_ff + 1'b1;
               if (i_ff + 1'b1 == PW'(len_ff)) begin
                  k_in     = '0;
                  state_in = S_FY_START;
               end else begin
                  state_in = S_OM_START;
               end
            end
         end
         S_FY_START: begin
            xinv_in  = rxinv_ff[HW'(k_ff)];
            acc_in   = '0;
            j_in     = len_ff - 1'b1;
            state_in = S_FY_NUM;
         end
         S_FY_NUM: begin
            acc_in = rsd_pkg::gf_mul(acc_ff, xinv_ff) ^ omega_ff[HW'(j_ff)];
            if (j_ff == '0) state_in = S_FY_X2;
            else j_in = j_ff - 1'b1;
         end
         S_FY_X2: begin
            num_in   = acc_ff;
            xinv2_in = rsd_pkg::gf_mul(xinv_ff, xinv_ff);
            acc_in   = '0;
            j_in     = (len_ff - 1'b1) >> 1;
            state_in = S_FY_DEN;
         end
         S_FY_DEN: begin
            acc_in = rsd_pkg::gf_mul(acc_ff, xinv2_ff) ^ loc_ff[SW'({j_ff, 1'b0})];
            if (j_ff == '0) state_in = S_FY_DIV;
            else j_in = j_ff - 1'b1;
         end
         S_FY_DIV: begin
            // zero derivative gives zero magnitude: inverse of zero reads zero
            acc_in   = rsd_pkg::gf_mul(num_ff, rsd_pkg::GF_INV[acc_ff]);
            state_in = S_FY_MAG;
         end
         S_FY_MAG: begin
            mag_in[HW'(k_ff)] = rsd_pkg::gf_mul(acc_ff, rsd_pkg::GF_INV[xinv_ff]);
            k_in              = k_ff + 1'b1;
            if (k_ff + 1'b1 == len_ff) begin
               nerr_in  = len_ff;
               dpos_in  = '0;
               slot_in  = '0;
               word_in  = '0;
               state_in = S_EM_RD;
            end else begin
               state_in = S_FY_START;
            end
         end
         S_EM_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_EM_DATA;
         end
         S_EM_DATA: begin
            word_in[slot_ff[2:0]] = fixed_byte;
            slot_in               = slot_ff + 1'b1;
            dpos_in               = dpos_ff + 1'b1;
            if ((slot_ff == 4'd7) || (dpos_ff == PW'(rsd_pkg::DATA_BYTES - 1))) begin
               state_in = S_EM_PUSH;
            end else begin
               state_in = S_EM_RD;
            end
         end
         S_EM_PUSH: begin
            if (out_free) begin
               ov_in     = 1'b1;
               oword_in  = word_ff;
               ocount_in = slot_ff;
               ook_in    = 1'b1;
               ofixed_in = 5'(nerr_ff);
               olast_in  = (dpos_ff == PW'(rsd_pkg::DATA_BYTES));
               word_in   = '0;
               slot_in   = '0;
               state_in  = (dpos_ff == PW'(rsd_pkg::DATA_BYTES)) ? S_DONE : S_EM_RD;
            end
         end
         S_FAIL: begin
            if (out_free) begin
               ov_in     = 1'b1;
               oword_in  = '0;
               ocount_in = '0;
               ook_in    = 1'b0;
               ofixed_in = '0;
               olast_in  = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            rel.valid = 1'b1;
            rel.bank  = bank_ff;
            bank_in   = ~bank_ff;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bank_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         ov_ff    <= ov_in;
      end
      syn_ff    <= syn_in;
      loc_ff    <= loc_in;
      prior_ff  <= prior_in;
      chien_ff  <= chien_in;
      len_ff    <= len_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      acc_ff    <= acc_in;
      dinv_ff   <= dinv_in;
      xr_ff     <= xr_in;
      roots_ff  <= roots_in;
      rpos_ff   <= rpos_in;
      rxinv_ff  <= rxinv_in;
      omega_ff  <= omega_in;
      mag_ff    <= mag_in;
      k_ff      <= k_in;
      xinv_ff   <= xinv_in;
      xinv2_ff  <= xinv2_in;
      num_ff    <= num_in;
      nerr_ff   <= nerr_in;
      word_ff   <= word_in;
      slot_ff   <= slot_in;
      dpos_ff   <= dpos_in;
      oword_ff  <= oword_in;
      ocount_ff <= ocount_in;
      ook_ff    <= ook_in;
      ofixed_ff <= ofixed_in;
      olast_ff  <= olast_in;
   end

   assign ram_rd_addr      = {bank_ff, dpos_ff};
   assign rsp_valid        = ov_ff;
   assign rsp_data_word    = oword_ff;
   assign rsp_byte_count   = ocount_ff;
   assign rsp_block_ok     = ook_ff;
   assign rsp_errors_fixed = ofixed_ff;
   assign rsp_last         = olast_ff;

endmodule

// ===== hw/rtl/rs_block_decoder.sv =====
// Input: one byte per cycle while a block buffer is free and the syndrome queue is not
// full; two buffers, so the next block streams in while the previous one decodes.
// Decode per block: PARITY_BYTES Berlekamp-Massey steps, a Chien search over all BLOCK_LEN
// positions, the error evaluator, a Forney step per error, then each data byte is read and
// corrected into result beats; all-zero syndromes skip straight to that last step.
// Reset: synchronous, active high; clears control state and input syndrome accumulators only.
`timescale 1ns / 1ps
module rs_block_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_data_word,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_block_ok,
   output logic [4:0]  rsp_errors_fixed,
   output logic        rsp_last
);

   logic                        ram_wr_en, ram_rd_en;
   logic [rsd_pkg::ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   rsd_pkg::gf_type             ram_wr_data, ram_rd_data;
   logic                        q_push, q_full, q_pop, q_valid;
   rsd_pkg::syn_set_type        q_in_data, q_head_data;
   rsd_pkg::bank_rel_type       rel;

   rsd_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .q_push      (q_push),
      .q_data      (q_in_data),
      .q_full      (q_full),
      .rel         (rel)
   );

   rsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .head_data (q_head_data)
   );

   rsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_head_data),
      .q_pop            (q_pop),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rel              (rel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_word    (rsp_data_word),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_block_ok     (rsp_block_ok),
      .rsp_errors_fixed (rsp_errors_fixed),
      .rsp_last         (rsp_last)
   );

`ifndef ASSERT_OFF
   a_no_q_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full && !q_pop))
      else $error("syndrome queue overflow");

   a_fail_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_block_ok) |-> (rsp_last && rsp_byte_count == 4'd0 &&
                                        rsp_data_word == 64'd0))
      else $error("malformed failure beat");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_ok) |-> (rsp_byte_count != 4'd0 &&
                                       rsp_byte_count <= 4'd8))
      else $error("bad byte count");
`endif

endmodule
